// File: hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LOBM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LOBM_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `LOBM_ASSERT(lbl, clk, rst, !(cond), msg)
`else
`define LOBM_ASSERT(lbl, clk, rst, prop, msg)
`define LOBM_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// File: hdl/lobm_pkg.sv
// types and constants of the order book matcher
package lobm_pkg;
   localparam int BOOK_W = 2;
   localparam int PRICE_W = 10;
   localparam int QTY_W = 16;
   localparam int TAG_W = 32;
   localparam int SESS_W = 8;
   localparam int KIND_W = 3;
   localparam int CFG_W = 3;
   localparam int BOOK_SLOTS = 4;
   localparam int ENTRY_W = TAG_W + SESS_W + QTY_W;

   localparam logic [KIND_W-1:0] KIND_FILL = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ACK = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BAD_BOOK = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BAD_PRICE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd4;

   localparam logic [CFG_W-1:0] BOOKS_RESET = 3'd3;

   typedef struct packed {
      logic [SESS_W-1:0]  session;
      logic [TAG_W-1:0]   order_tag;
      logic [QTY_W-1:0]   quantity;
      logic [PRICE_W-1:0] price_tick;
      logic               side;
      logic [BOOK_W-1:0]  book;
   } req_item_type;

   typedef struct packed {
      logic               last;
      logic [QTY_W-1:0]   resting_left;
      logic [SESS_W-1:0]  resting_session;
      logic [TAG_W-1:0]   resting_tag;
      logic [QTY_W-1:0]   incoming_left;
      logic [PRICE_W-1:0] fill_price;
      logic [QTY_W-1:0]   trade_qty;
      logic [KIND_W-1:0]  kind;
   } rsp_item_type;
endpackage

// File: hdl/lobm_ram.sv
// simple dual port memory with registered read
module lobm_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: hdl/lobm_seq.sv
// order sequencer: matching, resting and best price rescans over the memories
module lobm_seq #(
   parameter int NUM_BOOKS = 4,
   parameter int PRICE_LEVELS = 1001,
   parameter int LEVEL_DEPTH = 64,
   parameter int MAX_MATCHES = 63,
   localparam int RING_COUNT = NUM_BOOKS * 2 * PRICE_LEVELS,
   localparam int RING_AW = $clog2(RING_COUNT),
   localparam int ENT_AW = $clog2(RING_COUNT * LEVEL_DEPTH),
   localparam int PW = $clog2(LEVEL_DEPTH),
   localparam int CW = $clog2(LEVEL_DEPTH + 1),
   localparam int RGW = CW + 2 * PW
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lobm_pkg::CFG_W-1:0]  books_in_use,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  lobm_pkg::req_item_type      req_item,
   input  logic                        out_free,
   output logic                        emit,
   output lobm_pkg::rsp_item_type      emit_item,
   output logic                        r_we,
   output logic [RING_AW-1:0]          r_waddr,
   output logic [RGW-1:0]              r_wdata,
   output logic                        r_re,
   output logic [RING_AW-1:0]          r_raddr,
   input  logic [RGW-1:0]              r_rdata,
   output logic                        e_we,
   output logic [ENT_AW-1:0]           e_waddr,
   output logic [lobm_pkg::ENTRY_W-1:0] e_wdata,
   output logic                        e_re,
   output logic [ENT_AW-1:0]           e_raddr,
   input  logic [lobm_pkg::ENTRY_W-1:0] e_rdata
);
   localparam int LW = $clog2(PRICE_LEVELS + 1);
   localparam int MCW = $clog2(MAX_MATCHES + 1);
   localparam logic [LW-1:0] NO_PRICE = LW'(PRICE_LEVELS);

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b0000000001,
      S_IDLE     = 10'b0000000010,
      S_CHECK    = 10'b0000000100,
      S_MATCH    = 10'b0000001000,
      S_RING     = 10'b0000010000,
      S_ENT      = 10'b0000100000,
      S_SCAN_RD  = 10'b0001000000,
      S_SCAN_CHK = 10'b0010000000,
      S_REST_RD  = 10'b0100000000,
      S_REST     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   lobm_pkg::req_item_type ord_ff, ord_in;
   logic [lobm_pkg::QTY_W-1:0] rem_ff, rem_in;
   logic [MCW-1:0] mc_ff, mc_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [LW-1:0] scan_ff, scan_in;
   logic [RING_AW-1:0] ridx_ff, ridx_in;
   logic [RING_AW-1:0] clr_ff, clr_in;
   logic [LW-1:0] bid_ff [lobm_pkg::BOOK_SLOTS];
   logic [LW-1:0] ask_ff [lobm_pkg::BOOK_SLOTS];
   logic [LW-1:0] bid_in [lobm_pkg::BOOK_SLOTS];
   logic [LW-1:0] ask_in [lobm_pkg::BOOK_SLOTS];

   logic [PW-1:0] rd_head, rd_tail;
   logic [CW-1:0] rd_cnt;
   logic [lobm_pkg::QTY_W-1:0] rq, tq;
   logic [LW-1:0] best_lvl;
   logic opp;

   function automatic logic [RING_AW-1:0] ring_addr(input logic [1:0] bk, input logic sd,
                                                    input logic [LW-1:0] lvl);
      ring_addr = RING_AW'((int'(bk) * 2 + int'(sd)) * PRICE_LEVELS + int'(lvl));
   endfunction

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      ptr_next = (int'(p) == LEVEL_DEPTH - 1) ? '0 : PW'(int'(p) + 1);
   endfunction

   function automatic logic [ENT_AW-1:0] ent_addr(input logic [RING_AW-1:0] r,
                                                 input logic [PW-1:0] p);
      ent_addr = ENT_AW'(int'(r) * LEVEL_DEPTH + int'(p));
   endfunction

   assign rd_head = r_rdata[PW-1:0];
   assign rd_tail = r_rdata[2*PW-1:PW];
   assign rd_cnt = r_rdata[RGW-1:2*PW];
   assign rq = e_rdata[lobm_pkg::QTY_W-1:0];
   assign tq = (rem_ff < rq) ? rem_ff : rq;
   assign opp = ~ord_ff.side;
   assign best_lvl = ord_ff.side ? bid_ff[ord_ff.book] : ask_ff[ord_ff.book];

   always_comb begin
      state_in = state_ff;
      ord_in = ord_ff;
      rem_in = rem_ff;
      mc_in = mc_ff;
      lvl_in = lvl_ff;
      scan_in = scan_ff;
      ridx_in = ridx_ff;
      clr_in = clr_ff;
      bid_in = bid_ff;
      ask_in = ask_ff;
      req_ready = 1'b0;
      emit = 1'b0;
      emit_item = '0;
      r_we = 1'b0;
      r_waddr = ridx_ff;
      r_wdata = '0;
      r_re = 1'b0;
      r_raddr = ridx_ff;
      e_we = 1'b0;
      e_waddr = '0;
      e_wdata = '0;
      e_re = 1'b0;
      e_raddr = '0;
      case (state_ff)
         S_CLEAR: begin
            r_we = 1'b1;
            r_waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == RING_AW'(RING_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ord_in = req_item;
               rem_in = req_item.quantity;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            mc_in = '0;
            if (rem_ff == '0) begin
               state_in = S_IDLE;
            end else if ({1'b0, ord_ff.book} >= books_in_use ||
                         32'(ord_ff.book) >= 32'(NUM_BOOKS)) begin
               emit_item.kind = lobm_pkg::KIND_BAD_BOOK;
               emit_item.last = 1'b1;
               if (out_free) begin
                  emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (32'(ord_ff.price_tick) >= 32'(PRICE_LEVELS)) begin
               emit_item.kind = lobm_pkg::KIND_BAD_PRICE;
               emit_item.last = 1'b1;
               if (out_free) begin
                  emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            if (rem_ff == '0) begin
               state_in = S_IDLE;
            end else if (32'(mc_ff) >= 32'(MAX_MATCHES)) begin
               emit_item.kind = lobm_pkg::KIND_CANCEL;
               emit_item.last = 1'b1;
               if (out_free) begin
                  emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (best_lvl >= NO_PRICE ||
                         (!ord_ff.side && 32'(best_lvl) > 32'(ord_ff.price_tick)) ||
                         (ord_ff.side && 32'(best_lvl) < 32'(ord_ff.price_tick))) begin
               r_re = 1'b1;
               r_raddr = ring_addr(ord_ff.book, ord_ff.side, LW'(ord_ff.price_tick));
               state_in = S_REST_RD;
            end else begin
               r_re = 1'b1;
               r_raddr = ring_addr(ord_ff.book, opp, best_lvl);
               ridx_in = r_raddr;
               lvl_in = best_lvl;
               state_in = S_RING;
            end
         end
         S_RING: begin
            if (rd_cnt == '0) begin
               scan_in = lvl_ff;
               state_in = S_SCAN_RD;
            end else begin
               e_re = 1'b1;
               e_raddr = ent_addr(ridx_ff, rd_head);
               state_in = S_ENT;
            end
         end
         S_ENT: begin
            emit_item.kind = lobm_pkg::KIND_FILL;
            emit_item.trade_qty = tq;
            emit_item.fill_price = lobm_pkg::PRICE_W'(lvl_ff);
            emit_item.incoming_left = rem_ff - tq;
            emit_item.resting_tag = e_rdata[lobm_pkg::ENTRY_W-1:24];
            emit_item.resting_session = e_rdata[23:16];
            emit_item.resting_left = rq - tq;
            emit_item.last = (rem_ff == tq);
            if (out_free) begin
               emit = 1'b1;
               e_we = 1'b1;
               e_waddr = ent_addr(ridx_ff, rd_head);
               e_wdata = {e_rdata[lobm_pkg::ENTRY_W-1:16], rq - tq};
               rem_in = rem_ff - tq;
               mc_in = mc_ff + 1'b1;
               state_in = S_MATCH;
               if (rq == tq) begin
                  r_we = 1'b1;
                  r_wdata = {rd_cnt - 1'b1, rd_tail, ptr_next(rd_head)};
                  if (rd_cnt == CW'(1)) begin
                     scan_in = lvl_ff;
                     state_in = S_SCAN_RD;
                  end
               end
            end
         end
         S_SCAN_RD: begin
            r_re = 1'b1;
            r_raddr = ring_addr(ord_ff.book, opp, scan_ff);
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            state_in = S_MATCH;
            if (rd_cnt != '0) begin
               if (opp) begin
                  ask_in[ord_ff.book] = scan_ff;
               end else begin
                  bid_in[ord_ff.book] = scan_ff;
               end
            end else if (opp) begin
               if (scan_ff == LW'(PRICE_LEVELS - 1)) begin
                  ask_in[ord_ff.book] = NO_PRICE;
               end else begin
                  scan_in = scan_ff + 1'b1;
                  state_in = S_SCAN_RD;
               end
            end else begin
               if (scan_ff == '0) begin
                  bid_in[ord_ff.book] = NO_PRICE;
               end else begin
                  scan_in = scan_ff - 1'b1;
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_REST_RD: begin
            state_in = S_REST;
         end
         S_REST: begin
            emit_item.last = 1'b1;
            if (32'(rd_cnt) >= 32'(LEVEL_DEPTH)) begin
               emit_item.kind = lobm_pkg::KIND_BAD_PRICE;
               if (out_free) begin
                  emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               emit_item.kind = lobm_pkg::KIND_ACK;
               emit_item.incoming_left = rem_ff;
               if (out_free) begin
                  emit = 1'b1;
                  r_we = 1'b1;
                  r_waddr = ring_addr(ord_ff.book, ord_ff.side, LW'(ord_ff.price_tick));
                  r_wdata = {rd_cnt + 1'b1, ptr_next(rd_tail), rd_head};
                  e_we = 1'b1;
                  e_waddr = ent_addr(r_waddr, rd_tail);
                  e_wdata = {ord_ff.order_tag, ord_ff.session, rem_ff};
                  if (!ord_ff.side) begin
                     if (bid_ff[ord_ff.book] >= NO_PRICE ||
                         32'(ord_ff.price_tick) > 32'(bid_ff[ord_ff.book])) begin
                        bid_in[ord_ff.book] = LW'(ord_ff.price_tick);
                     end
                  end else begin
                     if (ask_ff[ord_ff.book] >= NO_PRICE ||
                         32'(ord_ff.price_tick) < 32'(ask_ff[ord_ff.book])) begin
                        ask_in[ord_ff.book] = LW'(ord_ff.price_tick);
                     end
                  end
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         mc_ff <= '0;
         for (int i = 0; i < lobm_pkg::BOOK_SLOTS; i++) begin
            bid_ff[i] <= NO_PRICE;
            ask_ff[i] <= NO_PRICE;
         end
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         mc_ff <= mc_in;
         bid_ff <= bid_in;
         ask_ff <= ask_in;
      end
      ord_ff <= ord_in;
      rem_ff <= rem_in;
      lvl_ff <= lvl_in;
      scan_ff <= scan_in;
      ridx_ff <= ridx_in;
   end
endmodule

// File: hdl/limit_order_book_matcher.sv
// top level of the limit order book matcher
// Takes one limit order at a time and answers with its fills in price-time order,
// then a rested ack, a cancel of the leftover or a reject; an order of zero
// quantity gets no answer. After reset the block first clears all of its
// NUM_BOOKS*2*PRICE_LEVELS levels (8008 with the defaults), one level a cycle,
// while req_tready stays low. An order is then checked; each fill reads the level
// table and the order entry and writes the entry back, and the level too once its
// head order is used up; a best price search reads levels one by one; resting
// reads the level and writes both memories, each with one read and one write port.
module limit_order_book_matcher #(
   parameter int NUM_BOOKS = 4,
   parameter int PRICE_LEVELS = 1001,
   parameter int LEVEL_DEPTH = 64,
   parameter int MAX_MATCHES = 63
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [2:0]   csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,  // price_tick, quantity, order_tag, session
   input  logic [2:0]   req_tuser,  // book, side
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // trade_qty, fill_price, incoming_left, resting_tag, resting_session, resting_left
   output logic [103:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,  // kind
   output logic         rsp_tlast
);
   `include "assert_macros.svh"

   localparam int RING_COUNT = NUM_BOOKS * 2 * PRICE_LEVELS;
   localparam int RING_AW = $clog2(RING_COUNT);
   localparam int ENT_AW = $clog2(RING_COUNT * LEVEL_DEPTH);
   localparam int PW = $clog2(LEVEL_DEPTH);
   localparam int CW = $clog2(LEVEL_DEPTH + 1);
   localparam int RGW = CW + 2 * PW;

   logic [lobm_pkg::CFG_W-1:0] books_ff;
   logic rsp_valid_ff, rsp_valid_in;
   lobm_pkg::rsp_item_type rsp_ff, rsp_in;
   lobm_pkg::req_item_type req_item;
   lobm_pkg::rsp_item_type emit_item;
   logic out_free, emit;
   logic r_we, r_re, e_we, e_re;
   logic [RING_AW-1:0] r_waddr, r_raddr;
   logic [RGW-1:0] r_wdata, r_rdata;
   logic [ENT_AW-1:0] e_waddr, e_raddr;
   logic [lobm_pkg::ENTRY_W-1:0] e_wdata, e_rdata;

   assign req_item.book = req_tuser[1:0];
   assign req_item.side = req_tuser[2];
   assign req_item.price_tick = req_tdata[9:0];
   assign req_item.quantity = req_tdata[25:10];
   assign req_item.order_tag = req_tdata[57:26];
   assign req_item.session = req_tdata[65:58];

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);
   assign rsp_in = emit ? emit_item : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         books_ff <= lobm_pkg::BOOKS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            books_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_ff.kind;
   assign rsp_tlast = rsp_ff.last;
   assign rsp_tdata = {6'd0, rsp_ff.resting_left, rsp_ff.resting_session, rsp_ff.resting_tag,
                       rsp_ff.incoming_left, rsp_ff.fill_price, rsp_ff.trade_qty};

   lobm_seq #(
      .NUM_BOOKS(NUM_BOOKS),
      .PRICE_LEVELS(PRICE_LEVELS),
      .LEVEL_DEPTH(LEVEL_DEPTH),
      .MAX_MATCHES(MAX_MATCHES)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .books_in_use(books_ff),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_item(req_item),
      .out_free(out_free),
      .emit(emit),
      .emit_item(emit_item),
      .r_we(r_we),
      .r_waddr(r_waddr),
      .r_wdata(r_wdata),
      .r_re(r_re),
      .r_raddr(r_raddr),
      .r_rdata(r_rdata),
      .e_we(e_we),
      .e_waddr(e_waddr),
      .e_wdata(e_wdata),
      .e_re(e_re),
      .e_raddr(e_raddr),
      .e_rdata(e_rdata)
   );

   lobm_ram #(.DEPTH(RING_COUNT), .WIDTH(RGW)) u_ring_mem (
      .clock(clock),
      .we(r_we),
      .waddr(r_waddr),
      .wdata(r_wdata),
      .re(r_re),
      .raddr(r_raddr),
      .rdata(r_rdata)
   );

   lobm_ram #(.DEPTH(RING_COUNT * LEVEL_DEPTH), .WIDTH(lobm_pkg::ENTRY_W)) u_entry_mem (
      .clock(clock),
      .we(e_we),
      .waddr(e_waddr),
      .wdata(e_wdata),
      .re(e_re),
      .raddr(e_raddr),
      .rdata(e_rdata)
   );

   `LOBM_ASSERT(a_fill_qty, clock, reset, (rsp_tvalid && rsp_tuser == lobm_pkg::KIND_FILL) |-> rsp_tdata[15:0] != 16'd0, "fill with zero quantity")
   `LOBM_ASSERT(a_other_last, clock, reset, (rsp_tvalid && rsp_tuser != lobm_pkg::KIND_FILL) |-> rsp_tlast, "non-fill word without last")
   `LOBM_ASSERT_NEVER(a_one_order, clock, reset, $past(req_tvalid && req_tready) && req_tready, "order taken while one is in work")
endmodule

// File: tb/tb.sv
// self-checking testbench for the limit order book matcher
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BOOKS = 4;
   localparam int LEVELS = 1001;
   localparam int DEPTH = 64;
   localparam int MATCH_CAP = 63;
   localparam int NO_LEVEL = LEVELS;
   localparam int SETTLE = 2500;

   class book_scoreboard;
      lobm_pkg::rsp_item_type pending[$];
      bit [55:0] orders[int];
      int unsigned head_of[BOOKS*2*LEVELS];
      int unsigned tail_of[BOOKS*2*LEVELS];
      int unsigned count_of[BOOKS*2*LEVELS];
      int unsigned top_bid[BOOKS];
      int unsigned top_ask[BOOKS];
      int unsigned active_books;
      int errors;
      int fills, acks, rejects, cancels, words_in;

      function new();
         for (int b = 0; b < BOOKS; b++) begin
            top_bid[b] = NO_LEVEL;
            top_ask[b] = NO_LEVEL;
         end
         active_books = lobm_pkg::BOOKS_RESET;
      endfunction

      function int level_of(int unsigned bk, int unsigned sd, int unsigned lvl);
         return (bk * 2 + sd) * LEVELS + lvl;
      endfunction

      function void find_best(int unsigned bk, int unsigned sd, int unsigned lvl);
         int i;
         if (sd == 1) begin
            for (i = lvl; i < LEVELS; i++)
               if (count_of[level_of(bk, 1, i)] != 0) begin
                  top_ask[bk] = i;
                  return;
               end
            top_ask[bk] = NO_LEVEL;
         end else begin
            for (i = (lvl < LEVELS) ? lvl : LEVELS - 1; i >= 0; i--)
               if (count_of[level_of(bk, 0, i)] != 0) begin
                  top_bid[bk] = i;
                  return;
               end
            top_bid[bk] = NO_LEVEL;
         end
      endfunction

      function void push(logic [lobm_pkg::KIND_W-1:0] k, int unsigned tq, int unsigned px,
                         int unsigned left, bit [31:0] rtag, bit [7:0] rsess,
                         int unsigned rleft, bit lst);
         lobm_pkg::rsp_item_type r;
         r.kind = k;
         r.trade_qty = 16'(tq);
         r.fill_price = 10'(px);
         r.incoming_left = 16'(left);
         r.resting_tag = rtag;
         r.resting_session = rsess;
         r.resting_left = 16'(rleft);
         r.last = lst;
         pending.push_back(r);
         case (k)
            lobm_pkg::KIND_FILL: fills++;
            lobm_pkg::KIND_ACK: acks++;
            lobm_pkg::KIND_CANCEL: cancels++;
            default: rejects++;
         endcase
      endfunction

      function void note(lobm_pkg::req_item_type o);
         int unsigned bk, sd, px, opp, rem, lvl, r, slot, rq, tq, matched;
         bit [55:0] e;
         bk = o.book;
         sd = o.side;
         px = o.price_tick;
         rem = o.quantity;
         opp = sd ^ 1;
         words_in++;
         if (rem == 0)
            return;
         if (bk >= active_books || bk >= BOOKS) begin
            push(lobm_pkg::KIND_BAD_BOOK, 0, 0, 0, 0, 0, 0, 1);
            return;
         end
         if (px >= LEVELS) begin
            push(lobm_pkg::KIND_BAD_PRICE, 0, 0, 0, 0, 0, 0, 1);
            return;
         end
         matched = 0;
         while (rem > 0 && matched < MATCH_CAP) begin
            lvl = (sd == 0) ? top_ask[bk] : top_bid[bk];
            if (lvl >= NO_LEVEL)
               break;
            if (sd == 0 ? (lvl > px) : (lvl < px))
               break;
            r = level_of(bk, opp, lvl);
            if (count_of[r] == 0) begin
               find_best(bk, opp, lvl);
               continue;
            end
            slot = r * DEPTH + head_of[r];
            e = orders.exists(slot) ? orders[slot] : '0;
            rq = e[15:0];
            tq = rem < rq ? rem : rq;
            rem -= tq;
            rq -= tq;
            e[15:0] = 16'(rq);
            orders[slot] = e;
            matched++;
            push(lobm_pkg::KIND_FILL, tq, lvl, rem, e[55:24], e[23:16], rq, rem == 0);
            if (rq == 0) begin
               head_of[r] = (head_of[r] + 1) % DEPTH;
               count_of[r]--;
               if (count_of[r] == 0)
                  find_best(bk, opp, lvl);
            end
         end
         if (rem == 0)
            return;
         if (matched >= MATCH_CAP) begin
            push(lobm_pkg::KIND_CANCEL, 0, 0, 0, 0, 0, 0, 1);
            return;
         end
         r = level_of(bk, sd, px);
         if (count_of[r] >= DEPTH) begin
            push(lobm_pkg::KIND_BAD_PRICE, 0, 0, 0, 0, 0, 0, 1);
            return;
         end
         orders[r * DEPTH + tail_of[r]] = {o.order_tag, o.session, rem[15:0]};
         tail_of[r] = (tail_of[r] + 1) % DEPTH;
         count_of[r]++;
         if (sd == 0) begin
            if (top_bid[bk] >= NO_LEVEL || px > top_bid[bk])
               top_bid[bk] = px;
         end else begin
            if (top_ask[bk] >= NO_LEVEL || px < top_ask[bk])
               top_ask[bk] = px;
         end
         push(lobm_pkg::KIND_ACK, 0, 0, rem, 0, 0, 0, 1);
      endfunction

      function void compare(string name, longint unsigned exp, longint unsigned act);
         if (exp != act) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            errors++;
         end
      endfunction

      function void check(lobm_pkg::rsp_item_type a);
         lobm_pkg::rsp_item_type x;
         if (pending.size() == 0) begin
            $error("result word with nothing expected: kind %0d", a.kind);
            errors++;
            return;
         end
         x = pending.pop_front();
         compare("kind", x.kind, a.kind);
         compare("trade_qty", x.trade_qty, a.trade_qty);
         compare("fill_price", x.fill_price, a.fill_price);
         compare("incoming_left", x.incoming_left, a.incoming_left);
         compare("resting_tag", x.resting_tag, a.resting_tag);
         compare("resting_session", x.resting_session, a.resting_session);
         compare("resting_left", x.resting_left, a.resting_left);
         compare("last", x.last, a.last);
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_wen = 0;
   logic [2:0]   csr_wdata = '0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [71:0]  req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [103:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;

   book_scoreboard sb = new();
   int send_idle = 0;
   int recv_stall = 0;
   int hold_cycles = 0;

   always #10 clock = ~clock;

   limit_order_book_matcher i_dut (
      .clock(clock), .reset(reset),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // receiver stalls and long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      lobm_pkg::rsp_item_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.kind = rsp_tuser;
         a.trade_qty = rsp_tdata[15:0];
         a.fill_price = rsp_tdata[25:16];
         a.incoming_left = rsp_tdata[41:26];
         a.resting_tag = rsp_tdata[73:42];
         a.resting_session = rsp_tdata[81:74];
         a.resting_left = rsp_tdata[97:82];
         a.last = rsp_tlast;
         sb.check(a);
      end
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic send_order(lobm_pkg::req_item_type o);
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, o.session, o.order_tag, o.quantity, o.price_tick};
      req_tuser <= {o.side, o.book};
      do
         @(posedge clock);
      while (!req_tready);
      sb.note(o);
      if ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic order(int bk, int sd, int px, int qty, bit [31:0] tg, bit [7:0] ss);
      lobm_pkg::req_item_type o;
      o.book = 2'(bk);
      o.side = 1'(sd);
      o.price_tick = 10'(px);
      o.quantity = 16'(qty);
      o.order_tag = tg;
      o.session = ss;
      send_order(o);
   endtask

   task automatic random_order();
      int p, q, r;
      r = $urandom_range(0, 99);
      p = r < 80 ? $urandom_range(480, 520) : r < 92 ? $urandom_range(0, 1023)
                                                    : $urandom_range(1001, 1023);
      r = $urandom_range(0, 99);
      q = r < 5 ? 0 : r < 10 ? 65535 : r < 20 ? $urandom_range(0, 65535)
                                               : $urandom_range(1, 300);
      order($urandom_range(0, 3), $urandom_range(0, 1), p, q, $urandom(),
            8'($urandom_range(0, 255)));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_books(int v);
      drain();
      csr_wen <= 1'b1;
      csr_wdata <= 3'(v);
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.active_books = v;
   endtask

   initial begin
      int idle_of[4];
      int stall_of[4];
      int books_of[4];
      idle_of = '{0, 50, 0, 23};
      stall_of = '{0, 0, 50, 23};
      books_of = '{3, 4, 7, 1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed orders with the reset book count
      order(0, 0, 500, 0, 1, 1);
      order(3, 0, 500, 10, 2, 2);
      order(0, 1, 1001, 10, 3, 3);
      order(0, 0, 1023, 10, 4, 4);
      order(0, 0, 500, 100, 32'hFFFF_FFFF, 8'hFF);
      order(0, 0, 500, 50, 32'h1234_5678, 8'h5A);
      order(0, 1, 400, 120, 7, 7);
      order(0, 1, 501, 10, 32'hA5A5_0001, 8'h81);
      order(0, 0, 1000, 65535, 8, 8);
      order(0, 1, 0, 65535, 9, 9);
      order(1, 1, 0, 1, 10, 10);
      order(1, 0, 0, 1, 11, 11);
      order(2, 0, 1000, 7, 0, 0);
      order(2, 1, 1000, 7, 12, 12);
      order(2, 1, 1000, 3, 13, 13);
      order(2, 0, 999, 3, 14, 14);

      for (int ph = 0; ph < 4; ph++) begin
         if (books_of[ph] != sb.active_books)
            write_books(books_of[ph]);
         send_idle = idle_of[ph];
         recv_stall = stall_of[ph];
         for (int i = 0; i < 6; i++) begin
            if (ph == 1 && i == 2)
               hold_cycles = 600;
            if (ph == 2 && i == 3)
               drain();
            random_order();
         end
      end

      // every book disabled
      write_books(0);
      for (int i = 0; i < 4; i++)
         random_order();

      // fill one level, overflow it, then sweep it under the match cap
      write_books(4);
      send_idle = 0;
      recv_stall = 10;
      for (int i = 0; i < DEPTH + 1; i++)
         order(3, 0, 1000, $urandom_range(1, 3), $urandom(), 8'(i));
      order(3, 1, 0, 60000, 32'hDEAD_BEEF, 8'h42);
      for (int i = 0; i < 4; i++)
         random_order();

      drain();
      $display("orders %0d: fills %0d, acks %0d, rejects %0d, cancels %0d",
               sb.words_in, sb.fills, sb.acks, sb.rejects, sb.cancels);
      $display("book counts 3, 4, 7, 1, 0 with idling and receiver stalls");
      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
